/* src/gpm_pkg.sv */
// types, codes and constants shared by the glob pattern matcher
package gpm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_NAME   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } rsp_t;

    typedef struct packed {
        logic [7:0] pbyte;
        logic       act;
        logic       nxt;
    } cell_t;

    typedef struct packed {
        logic shift;
        logic restart;
        logic commit;
    } cell_ctl_t;

endpackage

/* src/gpm_cell.sv */
// one pattern position: stored byte, active bit and next-step bit, in a rotating ring
module gpm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  gpm_pkg::cell_ctl_t ctl,
    input  logic              home,
    input  logic              wr_en,
    input  logic [7:0]        wr_byte,
    input  logic              set_nxt,
    input  gpm_pkg::cell_t    nb,
    output gpm_pkg::cell_t    q
);

    logic [7:0] pbyte_reg;
    logic       act_reg;
    logic       nxt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= home;
            nxt_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            act_reg <= nb.act;
            nxt_reg <= nb.nxt | set_nxt;
        end
        else if (ctl.restart)
        begin
            act_reg <= home;
            nxt_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            act_reg <= nxt_reg;
            nxt_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            pbyte_reg <= nb.pbyte;
        end
        else if (wr_en)
        begin
            pbyte_reg <= wr_byte;
        end
    end

    assign q = '{pbyte: pbyte_reg, act: act_reg, nxt: nxt_reg};

endmodule

/* src/glob_pattern_matcher_unit.sv */
// glob pattern matcher top level: ring of position cells and the scan sequencer
//
//  channel | direction | payload          | handshake
//  req     | in        | kind, data_byte  | req_valid / req_stall
//  rsp     | out       | matched, overflow| rsp_valid / rsp_stall
//
// clear and append are done straight from idle; with a non-empty pattern a name byte
// or end of name turns the cell ring round until it is aligned at the start again,
// and each active bracket class that is parsed adds a further turn of the ring.
// reset leaves an empty pattern with only the start position active
// a waiting response holds in its output register while further requests are taken
module glob_pattern_matcher_unit #(
    parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gpm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gpm_pkg::rsp_t rsp
);

    localparam int N  = PATTERN_MAX + 1;
    localparam int PW = $clog2(N);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_OUTER  = 7'b0000010,
        S_INNER  = 7'b0000100,
        S_RETURN = 7'b0001000,
        S_CLOSE  = 7'b0010000,
        S_ALIGN  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     rot_reg, rot_next;
    logic [PW-1:0]     len_reg, len_next;
    logic [PW-1:0]     jnext_reg, jnext_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        c_reg, c_next;
    logic              carry_reg, carry_next;
    logic              pend_reg, pend_next;
    logic              bang_reg, bang_next;
    logic              first_reg, first_next;
    logic              neg_reg, neg_next;
    logic              hit_reg, hit_next;
    logic [1:0]        skip_reg, skip_next;
    logic              mode_reg, mode_next;
    logic              rsp_valid_reg, rsp_valid_next;
    gpm_pkg::rsp_t     rsp_reg, rsp_next;

    gpm_pkg::cell_t     cq [N];
    gpm_pkg::cell_ctl_t ctl;
    logic               set0;
    logic               setl;
    logic               wr_go;
    logic               req_go;
    logic               in_range;
    logic               cur;
    logic               range_ok;
    logic [7:0]         hb, s1, s2;

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            logic set_k;
            if (k == 0)
            begin : g_first
                assign set_k = set0;
            end
            else if (k == N - 1)
            begin : g_last
                assign set_k = setl;
            end
            else
            begin : g_mid
                assign set_k = 1'b0;
            end
            gpm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .home    (k == 0),
                .wr_en   (wr_go && (len_reg == PW'(k))),
                .wr_byte (req.data_byte),
                .set_nxt (set_k),
                .nb      (cq[(k + 1) % N]),
                .q       (cq[k])
            );
        end
    endgenerate

    assign hb       = cq[0].pbyte;
    assign s1       = cq[1].pbyte;
    assign s2       = cq[2].pbyte;
    assign in_range = rot_reg < len_reg;
    assign cur      = cq[0].act | carry_reg;
    assign range_ok = (s1 == gpm_pkg::CH_DASH) && (s2 != gpm_pkg::CH_CLOSE)
                      && (({1'b0, rot_reg} + (PW + 1)'(2)) < {1'b0, len_reg});
    assign req_stall = (state_reg != S_IDLE);
    assign req_go    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        jnext_next     = jnext_reg;
        ovf_next       = ovf_reg;
        c_next         = c_reg;
        carry_next     = carry_reg;
        pend_next      = pend_reg;
        bang_next      = bang_reg;
        first_next     = first_reg;
        neg_next       = neg_reg;
        hit_next       = hit_reg;
        skip_next      = skip_reg;
        mode_next      = mode_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ctl            = '0;
        set0           = 1'b0;
        setl           = 1'b0;
        wr_go          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_go)
                begin
                    case (req.kind)
                        gpm_pkg::KIND_CLEAR:
                        begin
                            len_next    = '0;
                            ovf_next    = 1'b0;
                            ctl.restart = 1'b1;
                        end
                        gpm_pkg::KIND_APPEND:
                        begin
                            if (len_reg < PW'(PATTERN_MAX))
                            begin
                                wr_go    = 1'b1;
                                len_next = len_reg + PW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            ctl.restart = 1'b1;
                        end
                        gpm_pkg::KIND_NAME:
                        begin
                            c_next     = req.data_byte;
                            carry_next = 1'b0;
                            pend_next  = 1'b0;
                            mode_next  = 1'b0;
                            state_next = S_OUTER;
                        end
                        default:
                        begin
                            carry_next = 1'b0;
                            mode_next  = 1'b1;
                            state_next = S_CLOSE;
                        end
                    endcase
                end
            end
            S_OUTER:
            begin
                if (!in_range)
                begin
                    if (pend_reg)
                    begin
                        ctl.shift = 1'b1;
                        setl      = 1'b1;
                        pend_next = 1'b0;
                    end
                    state_next = S_ALIGN;
                end
                else
                begin
                    ctl.shift  = 1'b1;
                    pend_next  = 1'b0;
                    setl       = pend_reg;
                    carry_next = cur && (hb == gpm_pkg::CH_STAR);
                    if (cur)
                    begin
                        case (hb)
                            gpm_pkg::CH_STAR:  setl = 1'b1;
                            gpm_pkg::CH_QUERY: set0 = 1'b1;
                            gpm_pkg::CH_OPEN:
                            begin
                                jnext_next = rot_reg + PW'(1);
                                bang_next  = 1'b1;
                                first_next = 1'b1;
                                neg_next   = 1'b0;
                                hit_next   = 1'b0;
                                skip_next  = 2'd0;
                                state_next = S_INNER;
                            end
                            default:
                            begin
                                if (hb == c_reg)
                                begin
                                    set0 = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_INNER:
            begin
                ctl.shift = 1'b1;
                if (!in_range)
                begin
                    // no closing bracket: a plain '['
                    pend_next  = (c_reg == gpm_pkg::CH_OPEN);
                    state_next = S_RETURN;
                end
                else if (bang_reg && (hb == gpm_pkg::CH_BANG))
                begin
                    bang_next = 1'b0;
                    neg_next  = 1'b1;
                end
                else if (skip_reg != 2'd0)
                begin
                    skip_next = skip_reg - 2'd1;
                end
                else if ((hb == gpm_pkg::CH_CLOSE) && !first_reg)
                begin
                    set0       = hit_reg ^ neg_reg;
                    state_next = S_RETURN;
                end
                else
                begin
                    bang_next  = 1'b0;
                    first_next = 1'b0;
                    if (range_ok)
                    begin
                        skip_next = 2'd2;
                        if ((c_reg >= hb) && (c_reg <= s2))
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    else if (hb == c_reg)
                    begin
                        hit_next = 1'b1;
                    end
                end
            end
            S_RETURN:
            begin
                if (rot_reg == jnext_reg)
                begin
                    state_next = S_OUTER;
                end
                else
                begin
                    ctl.shift = 1'b1;
                end
            end
            S_CLOSE:
            begin
                if (in_range)
                begin
                    ctl.shift  = 1'b1;
                    carry_next = cur && (hb == gpm_pkg::CH_STAR);
                end
                else
                begin
                    hit_next   = cur;
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                if (rot_reg == '0)
                begin
                    if (mode_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ctl.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.shift = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.matched          = hit_reg && !ovf_reg;
                    rsp_next.pattern_overflow = ovf_reg;
                    rsp_valid_next            = 1'b1;
                    ctl.restart               = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (!ctl.shift)
        begin
            rot_next = rot_reg;
        end
        else if (rot_reg == PW'(N - 1))
        begin
            rot_next = '0;
        end
        else
        begin
            rot_next = rot_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            carry_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            bang_reg      <= 1'b0;
            first_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            skip_reg      <= 2'd0;
            mode_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_reg       <= rot_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            carry_reg     <= carry_next;
            pend_reg      <= pend_next;
            bang_reg      <= bang_next;
            first_reg     <= first_next;
            neg_reg       <= neg_next;
            hit_reg       <= hit_next;
            skip_reg      <= skip_next;
            mode_reg      <= mode_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jnext_reg <= jnext_next;
        c_reg     <= c_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (rot_reg == '0))
        else $error("cell ring not aligned while idle");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= PW'(PATTERN_MAX))
        else $error("pattern length beyond store");

    a_inner_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INNER) |-> (rot_reg <= len_reg))
        else $error("bracket scan ran past the pattern");

    a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.matched && rsp_reg.pattern_overflow))
        else $error("match reported on overflowed pattern");
`endif

endmodule

/* bench/glob_pattern_matcher_unit_test.sv */
// testbench for the glob pattern matcher: directed table and strings, then random requests against a predictor
module glob_pattern_matcher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PMAX = gpm_pkg::PATTERN_MAX_DEF;

    typedef struct {
        gpm_pkg::kind_t kind;
        logic [7:0]     data_byte;
        bit             has_want;
        bit             want_match;
        bit             want_ovf;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    gpm_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    gpm_pkg::rsp_t  rsp;

    glob_pattern_matcher_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [7:0]     pat [PMAX];
    int             pat_len = 0;
    bit             pat_ovf = 1'b0;
    bit             live [PMAX+1];
    gpm_pkg::rsp_t  match_queue [$];
    bit             failed = 1'b0;
    int             send_idle = 0;
    int             recv_idle = 0;

    function automatic void restart_live();
        foreach (live[j]) live[j] = 1'b0;
        live[0] = 1'b1;
    endfunction

    function automatic void close_stars();
        for (int j = 0; j < pat_len; j++)
            if (live[j] && pat[j] == gpm_pkg::CH_STAR) live[j+1] = 1'b1;
    endfunction

    function automatic void step_name(logic [7:0] c);
        bit nxt [PMAX+1];
        int i, cs, k;
        bit neg, hit;
        foreach (nxt[j]) nxt[j] = 1'b0;
        close_stars();
        for (int j = 0; j < pat_len; j++)
        begin
            if (!live[j]) continue;
            if (pat[j] == gpm_pkg::CH_STAR) nxt[j] = 1'b1;
            else if (pat[j] == gpm_pkg::CH_QUERY) nxt[j+1] = 1'b1;
            else if (pat[j] == gpm_pkg::CH_OPEN)
            begin
                i = j + 1;
                neg = 1'b0;
                if (i < pat_len && pat[i] == gpm_pkg::CH_BANG)
                begin
                    neg = 1'b1;
                    i++;
                end
                cs = i;
                if (i < pat_len && pat[i] == gpm_pkg::CH_CLOSE) i++;
                while (i < pat_len && pat[i] != gpm_pkg::CH_CLOSE) i++;
                if (i >= pat_len)
                begin
                    if (c == gpm_pkg::CH_OPEN) nxt[j+1] = 1'b1;
                end
                else
                begin
                    hit = 1'b0;
                    k = cs;
                    while (k < i)
                    begin
                        if (k + 2 < i && pat[k+1] == gpm_pkg::CH_DASH)
                        begin
                            if (c >= pat[k] && c <= pat[k+2]) hit = 1'b1;
                            k += 3;
                        end
                        else
                        begin
                            if (pat[k] == c) hit = 1'b1;
                            k += 1;
                        end
                    end
                    if (hit ^ neg) nxt[i+1] = 1'b1;
                end
            end
            else if (pat[j] == c) nxt[j+1] = 1'b1;
        end
        live = nxt;
    endfunction

    function automatic void predict(gpm_pkg::req_t r);
        gpm_pkg::rsp_t e;
        case (r.kind)
            gpm_pkg::KIND_CLEAR:
            begin
                pat_len = 0;
                pat_ovf = 1'b0;
                restart_live();
            end
            gpm_pkg::KIND_APPEND:
            begin
                if (pat_len < PMAX)
                begin
                    pat[pat_len] = r.data_byte;
                    pat_len++;
                end
                else pat_ovf = 1'b1;
                restart_live();
            end
            gpm_pkg::KIND_NAME: step_name(r.data_byte);
            default:
            begin
                close_stars();
                e.matched = live[pat_len] && !pat_ovf;
                e.pattern_overflow = pat_ovf;
                match_queue = {match_queue, e};
                restart_live();
            end
        endcase
    endfunction

    task automatic send(gpm_pkg::kind_t k, logic [7:0] b);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
        req_valid = 1'b1;
        req = '{kind: k, data_byte: b};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict('{kind: k, data_byte: b});
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send(gpm_pkg::KIND_APPEND, s[i]);
    endtask

    task automatic send_name(string s);
        foreach (s[i]) send(gpm_pkg::KIND_NAME, s[i]);
        send(gpm_pkg::KIND_END, 8'h00);
    endtask

    always @(negedge clk)
        rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (match_queue.size() == 0)
            begin
                $error("response with no request waiting");
                failed = 1'b1;
            end
            else
            begin
                if (rsp.matched !== match_queue[0].matched)
                begin
                    $error("matched expected %0b actual %0b",
                           match_queue[0].matched, rsp.matched);
                    failed = 1'b1;
                end
                if (rsp.pattern_overflow !== match_queue[0].pattern_overflow)
                begin
                    $error("pattern_overflow expected %0b actual %0b",
                           match_queue[0].pattern_overflow, rsp.pattern_overflow);
                    failed = 1'b1;
                end
                void'(match_queue.pop_front());
            end
        end
    end

    task automatic drain();
        while (match_queue.size() != 0) @(negedge clk);
    endtask

    function automatic byte pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 12) return gpm_pkg::CH_STAR;
        if (r < 20) return gpm_pkg::CH_QUERY;
        if (r < 28) return gpm_pkg::CH_OPEN;
        if (r < 34) return gpm_pkg::CH_CLOSE;
        if (r < 38) return gpm_pkg::CH_BANG;
        if (r < 43) return gpm_pkg::CH_DASH;
        if (r < 47) return byte'($urandom_range(255));
        return byte'("a" + $urandom_range(3));
    endfunction

    row_t table_rows [$];

    initial
    begin
        int sent;
        int nlen;
        int plen;
        table_rows = '{
            '{gpm_pkg::KIND_END,    8'h00, 1, 1, 0},
            '{gpm_pkg::KIND_NAME,   8'h00, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 0, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_STAR, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 1, 0},
            '{gpm_pkg::KIND_NAME,   8'hFF, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 1, 0},
            '{gpm_pkg::KIND_CLEAR,  8'hFF, 0, 0, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_QUERY, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 0, 0},
            '{gpm_pkg::KIND_NAME,   8'h00, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 1, 0},
            '{gpm_pkg::KIND_CLEAR,  8'h00, 0, 0, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_OPEN, 0, 0, 0},
            '{gpm_pkg::KIND_NAME,   gpm_pkg::CH_OPEN, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 1, 1, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_BANG, 0, 0, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_CLOSE, 0, 0, 0},
            '{gpm_pkg::KIND_APPEND, gpm_pkg::CH_CLOSE, 0, 0, 0},
            '{gpm_pkg::KIND_NAME,   8'h41, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 0, 0, 0},
            '{gpm_pkg::KIND_NAME,   gpm_pkg::CH_CLOSE, 0, 0, 0},
            '{gpm_pkg::KIND_END,    8'h00, 0, 0, 0},
            '{gpm_pkg::KIND_CLEAR,  8'h00, 0, 0, 0}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        restart_live();
        @(negedge clk);

        foreach (table_rows[i])
        begin
            send(table_rows[i].kind, table_rows[i].data_byte);
            if (table_rows[i].has_want && match_queue.size() != 0 &&
                (match_queue[match_queue.size()-1].matched !== table_rows[i].want_match ||
                 match_queue[match_queue.size()-1].pattern_overflow
                     !== table_rows[i].want_ovf))
            begin
                $error("table row %0d disagrees with predictor", i);
                failed = 1'b1;
            end
        end
        // ranges, dash ends, reversed range
        send_text("[-a-c]x[z-a]");
        send_name("bx");
        send_name("-xq");
        send(gpm_pkg::KIND_CLEAR, 8'h00);
        send_text("a*b?[!c-d-]");
        send_name("axxbqe");
        send_name("ab-z");
        // overflow then clear
        send(gpm_pkg::KIND_CLEAR, 8'h00);
        for (int i = 0; i < PMAX + 2; i++) send(gpm_pkg::KIND_APPEND, gpm_pkg::CH_STAR);
        send_name("q");
        drain();
        send(gpm_pkg::KIND_CLEAR, 8'h00);

        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 54 : 0;
            recv_idle = (phase == 0) ? 54 : (phase == 1) ? 36 : 0;
            while (sent < (phase + 1) * 217)
            begin
                if ($urandom_range(9) < 7)
                begin
                    send(gpm_pkg::KIND_CLEAR, 8'h00);
                    plen = ($urandom_range(19) == 0) ? $urandom_range(PMAX + 3)
                                                     : $urandom_range(8);
                    for (int i = 0; i < plen; i++)
                        send(gpm_pkg::KIND_APPEND, pick_char());
                    sent += plen + 1;
                end
                repeat ($urandom_range(1, 3))
                begin
                    nlen = $urandom_range(6);
                    for (int i = 0; i < nlen; i++)
                        send(gpm_pkg::KIND_NAME, ($urandom_range(3) == 0)
                             ? byte'($urandom_range(255)) : pick_char());
                    send(gpm_pkg::KIND_END, 8'($urandom_range(255)));
                    sent += nlen + 1;
                end
                if ($urandom_range(15) == 0)
                begin
                    send(gpm_pkg::kind_t'($urandom_range(3)), 8'($urandom_range(255)));
                    sent++;
                end
                if ($urandom_range(30) == 0) drain();
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #250ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
